/* src/apre_pkg.sv */
// apre_pkg: constants, codes and shared types of the playback rate estimator
// used by the channel interfaces, the shared arithmetic unit and the top level
`timescale 1ns / 1ps

package apre_pkg;

   // time base
   localparam longint unsigned PERIOD_USEC   = 250000;
   localparam int              SEC_FRAC_BITS = 16;
   localparam longint unsigned USEC_PER_SEC  = 1000000;
   localparam longint unsigned PERIOD_Q      = (PERIOD_USEC << SEC_FRAC_BITS) / USEC_PER_SEC;
   localparam longint unsigned ONE_SEC       = 64'd1 << SEC_FRAC_BITS;

   // ratio thresholds as cross-multiplication factors (0.7 and 1.3 per period)
   localparam longint unsigned LOW_K    = 7 * PERIOD_USEC;
   localparam longint unsigned HIGH_K   = 13 * PERIOD_USEC;
   localparam longint unsigned PF_SCALE = 10 * USEC_PER_SEC;

   // rate output in 1/256 Hz
   localparam int RATE_SHIFT = 8 + SEC_FRAC_BITS;

   // field widths
   localparam int OP_W     = 2;
   localparam int FRAMES_W = 16;
   localparam int USEC_W   = 40;
   localparam int POS_W    = 48;
   localparam int SECS_W   = 40;
   localparam int RATE_W   = 28;
   localparam int CFG_W    = 19;
   localparam int PER_W    = 32;

   // period index by reciprocal multiply, exact for every timestamp of USEC_W bits
   localparam int              PER_SHIFT = USEC_W + $clog2(PERIOD_USEC);
   localparam longint unsigned PER_RECIP =
      ((64'd1 << PER_SHIFT) + PERIOD_USEC - 1) / PERIOD_USEC;

   // shared unit widths
   localparam int ALU_W     = 112;
   localparam int DEN_W     = 64;
   localparam int MUL_STEPS = 48;
   localparam int CNT_W     = $clog2(ALU_W);

   // opcodes
   localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
   localparam logic [OP_W-1:0] OP_LOG     = 2'd1;
   localparam logic [OP_W-1:0] OP_PRELOG  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

   typedef struct packed {
      logic             start;
      logic             is_div;
      logic [ALU_W-1:0] x;
      logic [DEN_W-1:0] y;
   } alu_req_type;

   typedef struct packed {
      logic             done;
      logic [ALU_W-1:0] result;
   } alu_rsp_type;

endpackage

/* src/apre_if.sv */
// apre_if: valid/ready channel interfaces for requests, responses and the csr write
// depends on apre_pkg for field widths
`timescale 1ns / 1ps

interface apre_req_if;
   import apre_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [FRAMES_W-1:0] frames;
   logic [USEC_W-1:0]   now_usec;
   modport source (output valid, output opcode, output frames, output now_usec, input ready);
   modport sink (input valid, input opcode, input frames, input now_usec, output ready);
endinterface

interface apre_rsp_if;
   import apre_pkg::*;
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  frames_played;
   logic [POS_W-1:0]  frames_written;
   logic [RATE_W-1:0] rate_estimate;
   modport source (output valid, output frames_played, output frames_written,
                   output rate_estimate, input ready);
   modport sink (input valid, input frames_played, input frames_written,
                 input rate_estimate, output ready);
endinterface

interface apre_csr_if;
   import apre_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] expected_rate;
   modport source (output valid, output expected_rate, input ready);
   modport sink (input valid, input expected_rate, output ready);
endinterface

/* src/apre_alu.sv */
// apre_alu: shared bit-serial unit, shift-add multiply or restoring divide
// depends on apre_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module apre_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  apre_pkg::alu_req_type alu_req,
   output apre_pkg::alu_rsp_type alu_rsp
);
   import apre_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ALU_W-1:0] num_ff, num_in;
   logic [ALU_W-1:0] a_ff, a_in;
   logic [MUL_STEPS-1:0] b_ff, b_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] d_ff, d_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] dext;
   logic [DEN_W:0] diff;
   logic           ge;
   logic           last;

   // one multiply or divide step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      trial   = {rem_ff, num_ff[ALU_W-1]};
      dext    = {1'b0, d_ff};
      diff    = trial - dext;
      ge      = trial >= dext;
      last    = div_ff ? (cnt_ff == CNT_W'(ALU_W - 1)) : (cnt_ff == CNT_W'(MUL_STEPS - 1));
      if (alu_req.start) begin
         busy_in = 1'b1;
         div_in  = alu_req.is_div;
         cnt_in  = '0;
         num_in  = alu_req.is_div ? alu_req.x : '0;
         a_in    = alu_req.x;
         b_in    = alu_req.y[MUL_STEPS-1:0];
         rem_in  = '0;
         d_in    = alu_req.y;
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_in = {num_ff[ALU_W-2:0], ge};
         end else begin
            if (b_ff[0]) begin
               num_in = num_ff + a_ff;
            end
            a_in = {a_ff[ALU_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[MUL_STEPS-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = num_ff;

endmodule

/* src/audio_playback_rate_estimator_top.sv */
// audio_playback_rate_estimator_top: sequencer, estimator state and response register
// depends on apre_pkg, apre_if and apre_alu
`timescale 1ns / 1ps

// channel   dir  transaction
// req_ch    in   opcode, frames, now_usec
// rsp_ch    out  frames_played, frames_written, rate_estimate (one per request)
// csr_ch    in   expected_rate write, always ready
//
// one request at a time; the shared unit takes 48 steps per multiply and 112 per
// divide; a prelog needs only the rate divide, and a log closing a period with the
// ratio check needs the most operations. the next request can be accepted from the
// cycle in which the response goes valid.
// reset is synchronous and restores the restart state with 44100 frames/s.
// a held response stalls only the final load; the request side stays low meanwhile.

module audio_playback_rate_estimator_top (
   input logic clock,
   input logic reset,
   apre_req_if.sink   req_ch,
   apre_rsp_if.source rsp_ch,
   apre_csr_if.sink   csr_ch
);
   import apre_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LDIV  = 4'd1;
   localparam logic [3:0] S_FMUL  = 4'd2;
   localparam logic [3:0] S_FDIV  = 4'd3;
   localparam logic [3:0] S_PF10  = 4'd4;
   localparam logic [3:0] S_LEFT  = 4'd5;
   localparam logic [3:0] S_LOWR  = 4'd6;
   localparam logic [3:0] S_HIGHR = 4'd7;
   localparam logic [3:0] S_QDEN  = 4'd8;
   localparam logic [3:0] S_QMUL  = 4'd9;
   localparam logic [3:0] S_QDIV  = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;
   localparam logic [3:0] S_RATE  = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   function automatic logic [POS_W-1:0] sat48(input logic [ALU_W-1:0] x);
      return (|x[ALU_W-1:POS_W]) ? '1 : x[POS_W-1:0];
   endfunction
   function automatic logic [SECS_W-1:0] sat40(input logic [ALU_W-1:0] x);
      return (|x[ALU_W-1:SECS_W]) ? '1 : x[SECS_W-1:0];
   endfunction
   function automatic logic [RATE_W-1:0] sat28(input logic [ALU_W-1:0] x);
      return (|x[ALU_W-1:RATE_W]) ? '1 : x[RATE_W-1:0];
   endfunction
   function automatic logic [POS_W-1:0] sadd48(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? '1 : s[POS_W-1:0];
   endfunction
   function automatic logic [SECS_W-1:0] sadd40(input logic [SECS_W-1:0] a,
                                                input logic [SECS_W-1:0] b);
      logic [SECS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SECS_W] ? '1 : s[SECS_W-1:0];
   endfunction
   function automatic logic [PER_W-1:0] sadd32(input logic [PER_W-1:0] a,
                                               input logic [PER_W-1:0] b);
      logic [PER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PER_W] ? '1 : s[PER_W-1:0];
   endfunction

   logic [3:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [USEC_W-1:0]   now_ff, now_in;
   logic [PER_W-1:0]    l_ff, l_in;
   logic [ALU_W-1:0]    left_ff, left_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [CFG_W-1:0]    exp_rate_ff, exp_rate_in;

   logic [POS_W-1:0]  best_written_ff, best_written_in;
   logic [POS_W-1:0]  best_played_ff, best_played_in;
   logic [SECS_W-1:0] best_secs_ff, best_secs_in;
   logic [SECS_W-1:0] best_disc_ff, best_disc_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [POS_W-1:0]  ckpt_frames_ff, ckpt_frames_in;
   logic [USEC_W-1:0] ckpt_time_ff, ckpt_time_in;
   logic [POS_W-1:0]  run_frames_ff, run_frames_in;
   logic [SECS_W-1:0] run_secs_ff, run_secs_in;
   logic [SECS_W-1:0] run_disc_ff, run_disc_in;
   logic              first_ff, first_in;
   logic [PER_W-1:0]  last_period_ff, last_period_in;
   logic [PER_W-1:0]  period_frames_ff, period_frames_in;
   logic [POS_W-1:0]  last_pos_ff, last_pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_played_ff, rsp_played_in;
   logic [POS_W-1:0]  rsp_written_ff, rsp_written_in;
   logic [RATE_W-1:0] rsp_rate_ff, rsp_rate_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic              use_best;
   logic [POS_W-1:0]  pick_p;
   logic [SECS_W-1:0] pick_s;
   logic [SECS_W:0]   sx;
   logic [POS_W-1:0]  run_written;
   logic [POS_W-1:0]  w_sel;
   logic              do_restart, do_end, do_join, do_discard, do_finish;
   logic [PER_W-1:0]  lq;
   logic [PER_W-1:0]  pdiff;
   logic [POS_W-1:0]  q48;
   logic [POS_W-1:0]  pos_fwd;
   logic [POS_W:0]    pos_sum;
   logic [POS_W:0]    pos_bwd;
   logic [POS_W-1:0]  pos;
   logic              rsp_free;

   apre_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // rate source: best record while it spans more time than the current run
   always_comb begin
      use_best    = best_secs_ff > run_secs_ff;
      pick_p      = use_best ? best_played_ff : run_frames_ff;
      pick_s      = use_best ? best_secs_ff : run_secs_ff;
      sx          = use_best ? ({1'b0, best_secs_ff} + {1'b0, best_disc_ff})
                             : ({1'b0, run_secs_ff} + {1'b0, run_disc_ff});
      run_written = (total_ff >= ckpt_frames_ff) ? (total_ff - ckpt_frames_ff) : '0;
      w_sel       = use_best ? best_written_ff : run_written;
      rsp_free    = !rsp_valid_ff || rsp_ch.ready;
   end

   // position candidates from the divide result
   always_comb begin
      q48     = sat48(alu_rsp.result);
      pos_fwd = sadd48(ckpt_frames_ff, q48);
      if (pos_fwd > total_ff) begin
         pos_fwd = total_ff;
      end
      pos_sum = {1'b0, total_ff} + {1'b0, q48};
      pos_bwd = pos_sum - {1'b0, w_sel};
      if (pos_sum < {1'b0, w_sel}) begin
         pos = '0;
      end else if (pos_bwd[POS_W]) begin
         pos = '1;
      end else begin
         pos = pos_bwd[POS_W-1:0];
      end
      if (now_ff >= ckpt_time_ff) begin
         pos = pos_fwd;
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      frames_in        = frames_ff;
      now_in           = now_ff;
      l_in             = l_ff;
      left_in          = left_ff;
      den_in           = den_ff;
      rate_in          = rate_ff;
      exp_rate_in      = exp_rate_ff;
      best_written_in  = best_written_ff;
      best_played_in   = best_played_ff;
      best_secs_in     = best_secs_ff;
      best_disc_in     = best_disc_ff;
      total_in         = total_ff;
      ckpt_frames_in   = ckpt_frames_ff;
      ckpt_time_in     = ckpt_time_ff;
      run_frames_in    = run_frames_ff;
      run_secs_in      = run_secs_ff;
      run_disc_in      = run_disc_ff;
      first_in         = first_ff;
      last_period_in   = last_period_ff;
      period_frames_in = period_frames_ff;
      last_pos_in      = last_pos_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_played_in    = rsp_played_ff;
      rsp_written_in   = rsp_written_ff;
      rsp_rate_in      = rsp_rate_ff;
      alu_req          = '0;
      do_restart       = 1'b0;
      do_end           = 1'b0;
      do_join          = 1'b0;
      do_discard       = 1'b0;
      do_finish        = 1'b0;
      lq               = alu_rsp.result[PER_SHIFT +: PER_W];
      pdiff            = lq - last_period_ff;
      req_ch.ready     = (state_ff == S_IDLE);

      if (csr_ch.valid) begin
         exp_rate_in = csr_ch.expected_rate;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.opcode;
               frames_in = req_ch.frames;
               now_in    = req_ch.now_usec;
               case (req_ch.opcode)
                  OP_RESTART, OP_LOG: begin
                     alu_req.start = 1'b1;
                     alu_req.x     = ALU_W'(req_ch.now_usec);
                     alu_req.y     = DEN_W'(PER_RECIP);
                     state_in      = S_LDIV;
                  end
                  OP_PRELOG: begin
                     total_in = sadd48(total_ff, POS_W'(req_ch.frames));
                     state_in = S_FIN;
                  end
                  default: begin
                     alu_req.start = 1'b1;
                     if (req_ch.now_usec >= ckpt_time_ff) begin
                        alu_req.x = ALU_W'(USEC_PER_SEC);
                        alu_req.y = DEN_W'(pick_s);
                        state_in  = S_QDEN;
                     end else begin
                        alu_req.x = ALU_W'(sx);
                        alu_req.y = DEN_W'(pick_p);
                        state_in  = S_QMUL;
                     end
                  end
               endcase
            end
         end
         // period index of the timestamp, reciprocal multiply then shift
         S_LDIV: begin
            if (alu_rsp.done) begin
               l_in = lq;
               if (op_ff == OP_RESTART) begin
                  do_restart = 1'b1;
                  state_in   = S_FIN;
               end else if (lq == last_period_ff) begin
                  period_frames_in = sadd32(period_frames_ff, PER_W'(frames_ff));
                  total_in         = sadd48(total_ff, POS_W'(frames_ff));
                  state_in         = S_FIN;
               end else if (first_ff) begin
                  alu_req.start = 1'b1;
                  alu_req.x     = ALU_W'(period_frames_ff);
                  alu_req.y     = DEN_W'(pick_s);
                  state_in      = S_FMUL;
               end else if (lq < last_period_ff || pdiff > PER_W'(1)) begin
                  do_end    = 1'b1;
                  do_finish = 1'b1;
                  state_in  = S_FIN;
               end else begin
                  alu_req.start = 1'b1;
                  alu_req.x     = ALU_W'(period_frames_ff);
                  alu_req.y     = DEN_W'(PF_SCALE);
                  state_in      = S_PF10;
               end
            end
         end
         // first period: its duration at the current rate counts as discarded
         S_FMUL: begin
            if (alu_rsp.done) begin
               alu_req.start  = 1'b1;
               alu_req.is_div = 1'b1;
               alu_req.x      = alu_rsp.result;
               alu_req.y      = DEN_W'(pick_p);
               state_in       = S_FDIV;
            end
         end
         S_FDIV: begin
            if (alu_rsp.done) begin
               run_disc_in = sadd40(run_disc_ff, sat40(alu_rsp.result));
               first_in    = 1'b0;
               do_finish   = 1'b1;
               state_in    = S_FIN;
            end
         end
         // ratio check by cross multiplication
         S_PF10: begin
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.x     = alu_rsp.result;
               alu_req.y     = DEN_W'(best_secs_ff);
               state_in      = S_LEFT;
            end
         end
         S_LEFT: begin
            if (alu_rsp.done) begin
               left_in       = alu_rsp.result;
               alu_req.start = 1'b1;
               alu_req.x     = ALU_W'(LOW_K);
               alu_req.y     = DEN_W'(best_played_ff);
               state_in      = S_LOWR;
            end
         end
         S_LOWR: begin
            if (alu_rsp.done) begin
               if (left_ff < (alu_rsp.result << SEC_FRAC_BITS)) begin
                  do_end    = 1'b1;
                  do_finish = 1'b1;
                  state_in  = S_FIN;
               end else begin
                  alu_req.start = 1'b1;
                  alu_req.x     = ALU_W'(HIGH_K);
                  alu_req.y     = DEN_W'(best_played_ff);
                  state_in      = S_HIGHR;
               end
            end
         end
         S_HIGHR: begin
            if (alu_rsp.done) begin
               if (left_ff < (alu_rsp.result << SEC_FRAC_BITS)) begin
                  do_join = 1'b1;
               end else begin
                  do_discard = 1'b1;
               end
               do_finish = 1'b1;
               state_in  = S_FIN;
            end
         end
         // query: forward path needs the scaled denominator first
         S_QDEN: begin
            if (alu_rsp.done) begin
               den_in        = alu_rsp.result[DEN_W-1:0];
               alu_req.start = 1'b1;
               alu_req.x     = ALU_W'(now_ff - ckpt_time_ff);
               alu_req.y     = DEN_W'(pick_p);
               state_in      = S_QMUL;
            end
         end
         S_QMUL: begin
            if (alu_rsp.done) begin
               alu_req.start  = 1'b1;
               alu_req.is_div = 1'b1;
               if (now_ff >= ckpt_time_ff) begin
                  alu_req.x = alu_rsp.result << SEC_FRAC_BITS;
                  alu_req.y = den_ff;
               end else begin
                  alu_req.x = alu_rsp.result;
                  alu_req.y = DEN_W'(pick_s);
               end
               state_in = S_QDIV;
            end
         end
         S_QDIV: begin
            if (alu_rsp.done) begin
               if (pos > last_pos_ff) begin
                  last_pos_in = pos;
               end
               state_in = S_FIN;
            end
         end
         // rate estimate from the updated state
         S_FIN: begin
            alu_req.start  = 1'b1;
            alu_req.is_div = 1'b1;
            alu_req.x      = ALU_W'(pick_p) << RATE_SHIFT;
            alu_req.y      = DEN_W'(pick_s);
            state_in       = S_RATE;
         end
         S_RATE: begin
            if (alu_rsp.done) begin
               rate_in  = sat28(alu_rsp.result);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_played_in  = last_pos_ff;
               rsp_written_in = total_ff;
               rsp_rate_in    = rate_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // run bookkeeping at period close
      if (do_end) begin
         if (run_secs_ff > best_secs_ff) begin
            best_written_in = run_written;
            best_played_in  = run_frames_ff;
            best_secs_in    = run_secs_ff;
            best_disc_in    = run_disc_ff;
         end
         ckpt_frames_in = total_ff;
         ckpt_time_in   = now_ff;
         run_frames_in  = '0;
         run_secs_in    = '0;
         run_disc_in    = '0;
      end
      if (do_join) begin
         run_frames_in = sadd48(run_frames_ff, POS_W'(period_frames_ff));
         run_secs_in   = sadd40(run_secs_ff, SECS_W'(PERIOD_Q));
      end
      if (do_discard) begin
         run_disc_in = sadd40(run_disc_ff, SECS_W'(PERIOD_Q));
      end
      if (do_finish) begin
         period_frames_in = PER_W'(frames_ff);
         last_period_in   = l_ff;
         total_in         = sadd48(total_ff, POS_W'(frames_ff));
         if (state_ff == S_LDIV) begin
            last_period_in = lq;
         end
      end

      // restart from the configured rate
      if (do_restart) begin
         best_written_in  = POS_W'(exp_rate_ff);
         best_played_in   = POS_W'(exp_rate_ff);
         best_secs_in     = SECS_W'(ONE_SEC);
         best_disc_in     = '0;
         total_in         = '0;
         ckpt_frames_in   = '0;
         ckpt_time_in     = now_ff;
         run_frames_in    = '0;
         run_secs_in      = '0;
         run_disc_in      = '0;
         first_in         = 1'b1;
         last_period_in   = lq;
         period_frames_in = '0;
         last_pos_in      = '0;
      end
   end

   // control and estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         exp_rate_ff      <= CFG_W'(44100);
         best_written_ff  <= POS_W'(44100);
         best_played_ff   <= POS_W'(44100);
         best_secs_ff     <= SECS_W'(ONE_SEC);
         best_disc_ff     <= '0;
         total_ff         <= '0;
         ckpt_frames_ff   <= '0;
         ckpt_time_ff     <= '0;
         run_frames_ff    <= '0;
         run_secs_ff      <= '0;
         run_disc_ff      <= '0;
         first_ff         <= 1'b1;
         last_period_ff   <= '0;
         period_frames_ff <= '0;
         last_pos_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         exp_rate_ff      <= exp_rate_in;
         best_written_ff  <= best_written_in;
         best_played_ff   <= best_played_in;
         best_secs_ff     <= best_secs_in;
         best_disc_ff     <= best_disc_in;
         total_ff         <= total_in;
         ckpt_frames_ff   <= ckpt_frames_in;
         ckpt_time_ff     <= ckpt_time_in;
         run_frames_ff    <= run_frames_in;
         run_secs_ff      <= run_secs_in;
         run_disc_ff      <= run_disc_in;
         first_ff         <= first_in;
         last_period_ff   <= last_period_in;
         period_frames_ff <= period_frames_in;
         last_pos_ff      <= last_pos_in;
      end
   end

   // transaction payload and scratch
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      frames_ff      <= frames_in;
      now_ff         <= now_in;
      l_ff           <= l_in;
      left_ff        <= left_in;
      den_ff         <= den_in;
      rate_ff        <= rate_in;
      rsp_played_ff  <= rsp_played_in;
      rsp_written_ff <= rsp_written_in;
      rsp_rate_ff    <= rsp_rate_in;
   end

   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.frames_played  = rsp_played_ff;
   assign rsp_ch.frames_written = rsp_written_ff;
   assign rsp_ch.rate_estimate  = rsp_rate_ff;

endmodule
